### rtl/core/pgh_pkg.sv
// Package for the path string guid hash block.
// Holds the stage payload types and the hash constants used by all stages.
// No dependencies.
package pgh_pkg;

  // Bytes per input word; also the byte index value meaning "no terminator"
  localparam int unsigned WORD_BYTES = 4;
  localparam logic [2:0]  FULL_WORD  = 3'(WORD_BYTES);

  // Character handling
  localparam logic [7:0]  BSLASH     = 8'h5C;
  localparam logic [7:0]  SLASH_DIFF = 8'd45;
  localparam logic [31:0] CASE_MASK  = 32'hDFDF_DFDF;

  // Word mix multiplier 0xFB8C4D96501, split into its low 32 bits and the bits above
  localparam logic [31:0] FOLD_MUL_LO = 32'hC4D9_6501;
  localparam logic [11:0] FOLD_MUL_HI = 12'hFB8;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned MIX_W       = 64 - MIX_SHIFT;

  // Accumulator multiplier and fold shift
  localparam logic [26:0] ACC_MUL    = 27'h633_D5F1;
  localparam int unsigned FOLD_SHIFT = 61;

  // Length multiplier 0xAE502812AA7333, split into its low 32 bits and the bits above
  localparam logic [31:0] LEN_MUL_LO = 32'h12AA_7333;
  localparam logic [23:0] LEN_MUL_HI = 24'hAE_5028;

  // Partial products of the folded word
  typedef struct packed {
    logic [63:0] p_lo;     // folded * low half
    logic [31:0] p_hi;     // folded * high half, low 32 bits
    logic [2:0]  nbytes;   // bytes before terminator, FULL_WORD if none
  } prod_t;

  // Per-string result ahead of the length correction
  typedef struct packed {
    logic [63:0] sum;
    logic [31:0] len;
  } res_t;

endpackage

### rtl/core/pgh_fold.sv
// Input register and byte folding stage of the path string guid hash.
// Finds the terminator, maps backslash and case, forms the partial products.
// Depends on pgh_pkg.
module pgh_fold (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [31:0]    in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pgh_pkg::prod_t out_prod_o
);

  logic           in_valid_q;
  logic [31:0]    in_word_q;
  logic           p_valid_q;
  pgh_pkg::prod_t p_q;
  pgh_pkg::prod_t p_d;
  logic           p_free;
  logic [31:0]    kept;
  logic [31:0]    folded;
  logic [2:0]     nbytes;

  // Handshake between the two registers
  assign p_free     = !p_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || p_free;

  // Terminator scan and per-byte mapping
  always_comb begin
    logic       found;
    logic [7:0] b;
    found  = 1'b0;
    kept   = '0;
    nbytes = pgh_pkg::FULL_WORD;
    for (int k = 0; k < pgh_pkg::WORD_BYTES; k++) begin
      b = in_word_q[8*k +: 8];
      if (!found && b == 8'd0) begin
        found  = 1'b1;
        nbytes = 3'(k);
      end
      if (!found) begin
        kept[8*k +: 8] = (b == pgh_pkg::BSLASH) ? b - pgh_pkg::SLASH_DIFF : b;
      end
    end
  end

  assign folded = kept & pgh_pkg::CASE_MASK;

  // Two partial products of the word mix
  always_comb begin
    p_d.p_lo   = 64'(folded) * 64'(pgh_pkg::FOLD_MUL_LO);
    p_d.p_hi   = folded * 32'(pgh_pkg::FOLD_MUL_HI);
    p_d.nbytes = nbytes;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // Product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_free) begin
      p_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_free && in_valid_q) begin
      p_q <= p_d;
    end
  end

  assign out_valid_o = p_valid_q;
  assign out_prod_o  = p_q;

  // A byte index beyond the word would mean the scan is broken
  a_nbytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (p_q.nbytes <= pgh_pkg::FULL_WORD))
    else $error("byte index out of range");

endmodule

### rtl/core/pgh_accum.sv
// Mix register and accumulator stage of the path string guid hash.
// Keeps the running hash and byte count, emits sum and length at the terminator.
// Depends on pgh_pkg.
module pgh_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pgh_pkg::prod_t in_prod_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pgh_pkg::res_t  out_res_o
);

  logic                      m_valid_q;
  logic [pgh_pkg::MIX_W-1:0] m_mix_q;
  logic [2:0]                m_nbytes_q;
  logic [63:0]               mix_full;
  logic                      m_term;
  logic                      m_adv;
  logic                      m_free;
  logic                      r_free;
  logic                      r_valid_q;
  pgh_pkg::res_t             r_q;
  logic [63:0]               acc_q;
  logic [63:0]               acc_d;
  logic [31:0]               cnt_q;
  logic [31:0]               cnt_d;
  logic [58:0]               acc_lo_prod;
  logic [31:0]               acc_hi_prod;
  logic [63:0]               sum;

  // Combine the word products, keep bits above the mix shift
  assign mix_full = in_prod_i.p_lo + {in_prod_i.p_hi, 32'd0};

  // Stage control: plain words always drain, terminators need the result slot
  assign m_term     = m_nbytes_q != pgh_pkg::FULL_WORD;
  assign r_free     = !r_valid_q || out_ready_i;
  assign m_adv      = m_valid_q && (!m_term || r_free);
  assign m_free     = !m_valid_q || m_adv;
  assign in_ready_o = m_free;

  // Accumulator times multiplier, taken in two halves
  assign acc_lo_prod = 59'(acc_q[31:0]) * 59'(pgh_pkg::ACC_MUL);
  assign acc_hi_prod = acc_q[63:32] * 32'(pgh_pkg::ACC_MUL);
  assign sum = 64'(acc_lo_prod) + {acc_hi_prod, 32'd0} + 64'(m_mix_q);

  // Next state of the running hash
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (m_adv) begin
      if (m_term) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = sum ^ (sum >> pgh_pkg::FOLD_SHIFT);
        cnt_d = cnt_q + 32'(pgh_pkg::WORD_BYTES);
      end
    end
  end

  // Mix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_free) begin
      m_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_free && in_valid_i) begin
      m_mix_q    <= mix_full[63:pgh_pkg::MIX_SHIFT];
      m_nbytes_q <= in_prod_i.nbytes;
    end
  end

  // Running hash and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (r_free) begin
      r_valid_q <= m_adv && m_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_adv && m_term) begin
      r_q.sum <= sum;
      r_q.len <= cnt_q + 32'(m_nbytes_q);
    end
  end

  assign out_valid_o = r_valid_q;
  assign out_res_o   = r_q;

  // State is fresh after every terminator
  a_clear_after_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_adv && m_term) |=> (acc_q == 64'd0 && cnt_q == 32'd0))
    else $error("hash state not cleared after terminator");

  // A new result only ever comes from a terminator word
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(r_valid_q) |-> $past(m_adv && m_term))
    else $error("result without terminator");

  // A waiting terminator never changes the running state
  a_term_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_term && !r_free) |=> ($stable(acc_q) && $stable(cnt_q)))
    else $error("state moved while terminator stalled");

endmodule

### rtl/core/pgh_final.sv
// Length correction and output register of the path string guid hash.
// Multiplies the string length and subtracts it from the accumulated sum.
// Depends on pgh_pkg.
module pgh_final (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pgh_pkg::res_t in_res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   out_guid_o
);

  logic        l_valid_q;
  logic [63:0] l_sum_q;
  logic [63:0] l_plo_q;
  logic [31:0] l_phi_q;
  logic        l_free;
  logic        o_valid_q;
  logic [63:0] o_guid_q;
  logic        o_free;

  assign o_free     = !o_valid_q || out_ready_i;
  assign l_free     = !l_valid_q || o_free;
  assign in_ready_o = l_free;

  // Length partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (l_free) begin
      l_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_free && in_valid_i) begin
      l_sum_q <= in_res_i.sum;
      l_plo_q <= 64'(in_res_i.len) * 64'(pgh_pkg::LEN_MUL_LO);
      l_phi_q <= in_res_i.len * 32'(pgh_pkg::LEN_MUL_HI);
    end
  end

  // Output register: sum minus length term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_free) begin
      o_valid_q <= l_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && l_valid_q) begin
      o_guid_q <= l_sum_q - l_plo_q - {l_phi_q, 32'd0};
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_guid_o  = o_guid_q;

  // Length stage holds its item while the output slot is busy
  a_len_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_valid_q && !o_free) |=> (l_valid_q && $stable(l_sum_q) && $stable(l_plo_q)))
    else $error("length stage lost item under stall");

endmodule

### rtl/core/path_string_guid_hash_top.sv
// Path string guid hash, top level.
// Chains the fold, accumulator and length-correction stages.
// Depends on pgh_pkg, pgh_fold, pgh_accum, pgh_final.
//
// Usage:
//   The slave stream carries a NUL-terminated path, four characters per
//   transfer, first character in tdata[7:0]. Words with no zero byte only
//   advance the running hash. The word holding the terminator closes the
//   string; bytes after the terminator are ignored. One 64-bit guid per
//   string leaves on the master stream.
//   Throughput: one word per cycle while no stage is stalled. The accumulator
//   update is a loop through one register (two 32 x 27 partial products
//   plus an add), which sets that rate. Path: a terminator word passes
//   through the input, product, mix, result, length and output registers
//   before its guid leaves with tvalid high.
//   Reset clears all stage valids and the running hash and byte count.
//   When the receiver stalls, the guid holds; plain words keep draining into
//   the accumulator, and the slave side backs off once the stages holding
//   terminators are full.
module path_string_guid_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [63:0] guid
);

  logic           prod_valid;
  logic           prod_ready;
  pgh_pkg::prod_t prod;
  logic           res_valid;
  logic           res_ready;
  pgh_pkg::res_t  res;

  pgh_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_word_i   (s_axis_tdata_i),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_prod_o  (prod)
  );

  pgh_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_prod_i   (prod),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_res_o   (res)
  );

  pgh_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_guid_o  (m_axis_tdata_o)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for path_string_guid_hash_top.
// Streams NUL-terminated path words in and checks each guid against an in-bench hash predictor.
// Depends on the RTL of path_string_guid_hash_top and its package.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Hash constants
  localparam logic [63:0] MIX_MUL     = 64'h0000_0FB8_C4D9_6501;
  localparam logic [63:0] CHAIN_MUL   = 64'h0000_0000_0633_D5F1;
  localparam logic [63:0] LENGTH_MUL  = 64'h00AE_5028_12AA_7333;
  localparam logic [31:0] FOLD_MASK   = 32'hDFDF_DFDF;
  localparam logic [7:0]  BACKSLASH   = 8'h5C;
  localparam logic [7:0]  SLASH_STEP  = 8'd45;
  localparam int          XOR_SHIFT   = 61;
  localparam int          MIX_SHIFT   = 24;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          DRAIN_WAIT  = 12;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AFTER  = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;

  // Pending words, expected guids, predictor state
  logic [31:0] word_q[$];
  logic [63:0] guid_q[$];
  logic [63:0] hash_acc = '0;
  logic [31:0] byte_cnt = '0;
  int          words_sent = 0;
  int          total_words = 1;
  int          guids_seen = 0;
  int          errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  path_string_guid_hash_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),           // [31:0] word
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)    // [63:0] guid
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Idle phases: none, sender gaps, receiver stalls, both
  function automatic int send_idle_pct();
    case (words_sent * 4 / total_words)
      1:       return 67;
      3:       return 29;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (words_sent * 4 / total_words)
      2:       return 67;
      3:       return 29;
      default: return 0;
    endcase
  endfunction

  // Hash one word into the running state; returns 1 with the guid on a terminator
  function automatic bit hash_word(input logic [31:0] w, output logic [63:0] guid);
    logic [31:0] kept;
    logic [31:0] folded;
    logic [7:0]  b;
    logic [63:0] mixed;
    logic [63:0] sum;
    logic [31:0] len;
    int          nbytes;
    bit          found;
    kept = '0;
    nbytes = 4;
    found = 1'b0;
    guid = '0;
    for (int k = 0; k < 4; k++) begin
      b = w[8*k +: 8];
      if (!found) begin
        if (b == 8'h00) begin
          nbytes = k;
          found = 1'b1;
        end else begin
          if (b == BACKSLASH) b = b - SLASH_STEP;
          kept[8*k +: 8] = b;
        end
      end
    end
    folded = kept & FOLD_MASK;
    mixed = (MIX_MUL * {32'h0, folded}) >> MIX_SHIFT;
    sum = CHAIN_MUL * hash_acc + mixed;
    if (!found) begin
      hash_acc = (sum >> XOR_SHIFT) ^ sum;
      byte_cnt = byte_cnt + 32'd4;
      return 1'b0;
    end
    len = byte_cnt + 32'(nbytes);
    guid = sum - LENGTH_MUL * {32'h0, len};
    hash_acc = '0;
    byte_cnt = '0;
    return 1'b1;
  endfunction

  // Path character: backslashes and letters are favored
  function automatic logic [7:0] path_char();
    case ($urandom_range(3))
      0:       return BACKSLASH;
      1:       return 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(1) ? 8'h20 : 8'h00);
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Queue one string of nchars characters, terminator, then junk to a word boundary
  task automatic push_path(input int nchars);
    logic [31:0] w;
    int          idx;
    for (int i = 0; i <= nchars / 4; i++) begin
      w = '0;
      for (int j = 0; j < 4; j++) begin
        idx = 4 * i + j;
        if (idx < nchars) w[8*j +: 8] = path_char();
        else if (idx > nchars) w[8*j +: 8] = 8'($urandom_range(255));
      end
      word_q.push_back(w);
    end
  endtask

  // Driver: offers queued words, predicts each accepted transfer
  always @(posedge clk_i) begin
    logic [63:0] g;
    bit          take;
    if (rst_ni) begin
      take = s_valid && s_axis_tready_o;
      if (take) begin
        if (hash_word(s_data, g)) guid_q.push_back(g);
        words_sent <= words_sent + 1;
      end
      if (!s_valid || take) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          s_valid <= 1'b1;
          s_data  <= word_q.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks guids, drives ready, holds off once for a long stretch
  always @(posedge clk_i) begin
    logic [63:0] exp_guid;
    int          hl;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        guids_seen <= guids_seen + 1;
        if (guid_q.size() == 0) begin
          $error("guid: no expected value, actual %h", m_axis_tdata_o);
          errors++;
        end else begin
          exp_guid = guid_q.pop_front();
          if (m_axis_tdata_o !== exp_guid) begin
            $error("guid: expected %h, actual %h", exp_guid, m_axis_tdata_o);
            errors++;
          end
        end
      end
      hl = hold_left;
      if (!hold_done && guids_seen >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hl = HOLD_CYCLES;
      end
      if (hl > 0) begin
        m_ready   <= 1'b0;
        hold_left <= hl - 1;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct());
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("path_string_guid_hash_top: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Directed: empty strings, terminator in each lane, backslashes, case, extremes
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hFFFF_FF00);
    word_q.push_back(32'h0000_0061);
    word_q.push_back(32'hFFFF_0041);
    word_q.push_back(32'hAB00_5C5C);
    word_q.push_back(32'h005C_5C5C);
    word_q.push_back(32'h5C5C_5C5C);
    word_q.push_back(32'h4141_4141);
    word_q.push_back(32'h6161_6161);
    word_q.push_back(32'h2F2F_2F2F);
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back(32'h8080_8080);
    word_q.push_back(32'h7F7F_7F7F);
    word_q.push_back(32'h0101_0101);
    word_q.push_back(32'hFF00_FFFF);
    word_q.push_back(32'h00FF_FFFF);
    word_q.push_back(32'h0020_5A7A);
    word_q.push_back(32'h0000_0000);
    // Random: mostly well-formed paths, some raw words
    while (word_q.size() < 720) begin
      if ($urandom_range(9) == 0) word_q.push_back($urandom);
      else if ($urandom_range(19) == 0) push_path($urandom_range(100, 250));
      else push_path($urandom_range(0, 40));
    end
    total_words = word_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() > 0 || s_valid || guid_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (guid_q.size() > 0) begin
      $error("guid: %0d expected values never arrived", guid_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("path_string_guid_hash_top: match");
    end else begin
      $display("path_string_guid_hash_top: mismatch");
    end
    $finish;
  end

endmodule
